// ===== rtl/core/imu_dfr_pkg.sv =====
package imu_dfr_pkg;

  // Configuration register indexes.
  localparam logic CFG_SYNC_VALUE = 1'b0;
  localparam logic CFG_CRC_INIT   = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [7:0] SYNC_RESET     = 8'hA5;
  localparam logic [7:0] CRC_INIT_RESET = 8'hFF;

  // Reflected form of the CRC-8 polynomial 0x31.
  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

  // Frame positions: position 0 means hunting for sync.
  localparam logic [5:0] POS_HUNT  = 6'd0;
  localparam logic [5:0] POS_FIRST = 6'd1;
  localparam logic [5:0] CRC_POS   = 6'd58;
  localparam logic [5:0] CAP_FIRST = 6'd2;
  localparam logic [5:0] CAP_LAST  = 6'd45;

  // Captured bytes run from the time field through accel z.
  localparam int CAP_BYTES  = 44;
  localparam int CAP_BITS   = CAP_BYTES * 8;
  localparam int WORD_COUNT = CAP_BYTES / 4;

  // Word slots inside the captured block.
  localparam int W_TIME  = 0;
  localparam int W_QW    = 1;
  localparam int W_QX    = 2;
  localparam int W_QY    = 3;
  localparam int W_QZ    = 4;
  localparam int W_GX    = 5;
  localparam int W_GY    = 6;
  localparam int W_GZ    = 7;
  localparam int W_AX    = 8;
  localparam int W_AY    = 9;
  localparam int W_AZ    = 10;

  // Control and status from the frame controller.
  typedef struct packed {
    logic store_en;
    logic frame_done;
    logic crc_ok;
    logic at_crc;
  } ctrl_t;

  // One byte through the reflected CRC-8, one bit per step.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/imu_dfr_ctrl.sv =====
module imu_dfr_ctrl
  import imu_dfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output ctrl_t      ctrl
);

  logic [7:0] sync_value_r;
  logic [7:0] crc_init_r;
  logic [5:0] pos_r, pos_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       store_en;
  logic       frame_done;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r <= SYNC_RESET;
      crc_init_r   <= CRC_INIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_VALUE: sync_value_r <= cfg_wdata;
        CFG_CRC_INIT:   crc_init_r   <= cfg_wdata;
        default:        sync_value_r <= sync_value_r;
      endcase
    end
  end

  // Frame position and running CRC for each accepted byte.
  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    store_en   = 1'b0;
    frame_done = 1'b0;
    if (accept) begin
      if (pos_r == POS_HUNT) begin
        if (rx_byte == sync_value_r) begin
          crc_nxt = crc8_step(crc_init_r, rx_byte);
          pos_nxt = POS_FIRST;
        end
      end else if (pos_r < CRC_POS) begin
        crc_nxt  = crc8_step(crc_r, rx_byte);
        pos_nxt  = pos_r + 6'd1;
        store_en = (pos_r >= CAP_FIRST) && (pos_r <= CAP_LAST);
      end else begin
        frame_done = 1'b1;
        pos_nxt    = POS_HUNT;
        crc_nxt    = 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      crc_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
    end
  end

  assign ctrl.store_en   = store_en;
  assign ctrl.frame_done = frame_done;
  assign ctrl.crc_ok     = (crc_r == rx_byte);
  assign ctrl.at_crc     = (pos_r >= CRC_POS);

endmodule

// ===== rtl/core/imu_dfr_capture.sv =====
module imu_dfr_capture
  import imu_dfr_pkg::*;
(
  input  logic                clk,
  input  ctrl_t               ctrl,
  input  logic [7:0]          rx_byte,
  output logic [CAP_BITS-1:0] cap_data
);

  logic [CAP_BITS-1:0] shift_r;

  // Bytes enter at the top, so after the last one the first byte sits in the
  // low bits and each word lies little-endian at a fixed slice.
  always_ff @(posedge clk) begin
    if (ctrl.store_en) begin
      shift_r <= {rx_byte, shift_r[CAP_BITS-1:8]};
    end
  end

  assign cap_data = shift_r;

endmodule

// ===== rtl/core/imu_dfr_outreg.sv =====
module imu_dfr_outreg
  import imu_dfr_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_t               ctrl,
  input  logic [CAP_BITS-1:0] cap_data,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [31:0]         words [WORD_COUNT],
  output logic                crc_ok
);

  logic        valid_r, valid_nxt;
  logic [31:0] word_r [WORD_COUNT];
  logic        crc_ok_r;

  // Valid rises on a finished frame and falls once the word is taken.
  always_comb begin
    valid_nxt = valid_r;
    if (ctrl.frame_done) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload loads from the capture register at frame end.
  always_ff @(posedge clk) begin
    if (ctrl.frame_done) begin
      for (int k = 0; k < WORD_COUNT; k++) begin
        word_r[k] <= cap_data[32*k +: 32];
      end
      crc_ok_r <= ctrl.crc_ok;
    end
  end

  assign out_valid = valid_r;
  assign words     = word_r;
  assign crc_ok    = crc_ok_r;

endmodule

// ===== rtl/core/imu_frame_deframer_crc8.sv =====
// Channel   Direction  Ports                          Word
// in        input      in_valid, in_stall, in_rx_byte one received serial byte
// out       output     out_valid, out_stall, out_*    one decoded frame with crc_ok
// cfg       input      cfg_we, cfg_index, cfg_wdata   sync_value (0), crc_init (1)
//
// One byte is taken every cycle while in_valid is high and in_stall is low; the CRC update is combinational.
// A frame result appears in the cycle after its CRC byte is accepted.
// Reset is synchronous: the block hunts for sync, config registers return to defaults.
// The input stalls only when the CRC byte is next and the previous result
// is still waiting on a stalled output.
module imu_frame_deframer_crc8
  import imu_dfr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_timestamp,
  output logic [31:0] out_quat_w,
  output logic [31:0] out_quat_x,
  output logic [31:0] out_quat_y,
  output logic [31:0] out_quat_z,
  output logic [31:0] out_gyro_x,
  output logic [31:0] out_gyro_y,
  output logic [31:0] out_gyro_z,
  output logic [31:0] out_accel_x,
  output logic [31:0] out_accel_y,
  output logic [31:0] out_accel_z,
  output logic        out_crc_ok
);

  ctrl_t               ctrl;
  logic                accept;
  logic [CAP_BITS-1:0] cap_data;
  logic [31:0]         words [WORD_COUNT];

  // Only the frame-closing byte needs a free result register.
  assign in_stall = ctrl.at_crc && out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  imu_dfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .rx_byte   (in_rx_byte),
    .ctrl      (ctrl)
  );

  imu_dfr_capture u_capture (
    .clk      (clk),
    .ctrl     (ctrl),
    .rx_byte  (in_rx_byte),
    .cap_data (cap_data)
  );

  imu_dfr_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .cap_data  (cap_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .words     (words),
    .crc_ok    (out_crc_ok)
  );

  assign out_timestamp = words[W_TIME];
  assign out_quat_w    = words[W_QW];
  assign out_quat_x    = words[W_QX];
  assign out_quat_y    = words[W_QY];
  assign out_quat_z    = words[W_QZ];
  assign out_gyro_x    = words[W_GX];
  assign out_gyro_y    = words[W_GY];
  assign out_gyro_z    = words[W_GZ];
  assign out_accel_x   = words[W_AX];
  assign out_accel_y   = words[W_AY];
  assign out_accel_z   = words[W_AZ];

`ifndef SYNTHESIS
  // A stalled input always traces back to a waiting result.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled without a pending result");

  // A frame only closes on an accepted byte.
  a_done_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.frame_done |-> (in_valid && !in_stall))
    else $error("frame closed without an accepted byte");

  // A closed frame shows up as a result in the next cycle.
  a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.frame_done |=> out_valid)
    else $error("finished frame not presented");

  // A taken result clears unless a new frame closes at the same edge.
  a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !ctrl.frame_done) |=> !out_valid)
    else $error("result repeated after being taken");
`endif

endmodule
